/* hw/rtl/ddpa_pkg.sv */
// Shared types, constants and binary64 helper functions for the dot product accumulator.
package ddpa_pkg;

    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
    localparam int unsigned NORM_W = 106;

    typedef struct packed {
        logic [63:0] bits;
        logic        last;
    } t_prod;

    typedef struct packed {
        logic sgn;
        logic nan;
        logic inf;
        logic zero;
    } t_cls;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_NORM,
        ST_ROUND
    } t_back_state;

    // Count of leading zeros of a 106-bit significand; an all-zero word gives 0.
    function automatic logic [6:0] lzc106(input logic [NORM_W-1:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < NORM_W; i++) begin
            if (v[i]) begin
                n = 7'(NORM_W - 1 - i);
            end
        end
        return n;
    endfunction

    // Rounds a normalized significand (leading one at bit 105) whose leading bit has
    // biased exponent be, to nearest even, including gradual underflow and overflow.
    function automatic logic [63:0] round_pack(input logic sgn,
                                               input logic [NORM_W-1:0] sn,
                                               input logic signed [12:0] be);
        logic [6:0]          sh;
        logic signed [12:0]  bt;
        logic [NORM_W-1:0]   q;
        logic [NORM_W-1:0]   gv;
        logic [NORM_W-1:0]   mask;
        logic                g;
        logic                st;
        logic                up;
        logic [53:0]         m;
        logic [63:0]         res;
        if (be >= 13'sd1) begin
            bt = be;
            sh = 7'd53;
        end else begin
            bt = 13'sd1;
            if (be < -13'sd53) begin
                sh = 7'd107;
            end else begin
                sh = 7'(13'sd54 - be);
            end
        end
        q    = sn >> sh;
        gv   = sn >> (sh - 7'd1);
        g    = gv[0];
        mask = ~({NORM_W{1'b1}} << (sh - 7'd1));
        st   = |(sn & mask);
        up   = g & (st | q[0]);
        m    = {1'b0, q[52:0]} + 54'(up);
        if (m[53]) begin
            m  = m >> 1;
            bt = bt + 13'sd1;
        end
        if (bt >= 13'sd2047) begin
            res = {sgn, 11'h7FF, 52'd0};
        end else begin
            res = {sgn, (m[52] ? bt[10:0] : 11'd0), m[51:0]};
        end
        return res;
    endfunction

endpackage

/* hw/rtl/ddpa_front.sv */
// Front end: accepts element pairs and runs the pipelined binary64 multiplier.
module ddpa_front
    import ddpa_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [63:0]                     i_x_element,
    input  logic [63:0]                     i_y_element,
    input  logic                            i_last_element,
    input  logic [$clog2(DEPTH+1)-1:0]      i_fifo_count,
    output logic                            o_push,
    output t_prod                           o_push_data
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned TW = CW + 3;

    // Accept stage
    logic        r0_v;
    logic [63:0] r0_x;
    logic [63:0] r0_y;
    logic        r0_last;
    // Partial product stage
    logic               rA_v;
    logic [63:0]        rA_pll;
    logic [52:0]        rA_plh;
    logic [52:0]        rA_phl;
    logic [41:0]        rA_phh;
    logic signed [12:0] rA_be;
    t_cls               rA_cls;
    logic               rA_last;
    // Summed product stage
    logic               rB_v;
    logic [NORM_W-1:0]  rB_p;
    logic signed [12:0] rB_be;
    t_cls               rB_cls;
    logic               rB_last;
    // Normalized stage
    logic               rC_v;
    logic [NORM_W-1:0]  rC_sn;
    logic signed [12:0] rC_be;
    t_cls               rC_cls;
    logic               rC_last;

    logic [TW-1:0] total;
    logic          accept;
    logic [10:0]   ex;
    logic [10:0]   ey;
    logic [10:0]   ea;
    logic [10:0]   eb;
    logic [52:0]   ma;
    logic [52:0]   mb;
    t_cls          cls;
    logic          xnan, ynan, xinf, yinf, xzero, yzero;
    logic [6:0]    lz;
    logic [63:0]   res;

    // Items in the pipe are counted against the queue so a push never finds it full.
    assign total   = TW'(i_fifo_count) + TW'(r0_v) + TW'(rA_v) + TW'(rB_v) + TW'(rC_v);
    assign o_ready = total < TW'(DEPTH);
    assign accept  = i_valid & o_ready;

    always_comb begin
        ex    = r0_x[62:52];
        ey    = r0_y[62:52];
        ea    = (ex == 11'd0) ? 11'd1 : ex;
        eb    = (ey == 11'd0) ? 11'd1 : ey;
        ma    = {ex != 11'd0, r0_x[51:0]};
        mb    = {ey != 11'd0, r0_y[51:0]};
        xnan  = (ex == 11'h7FF) && (r0_x[51:0] != 52'd0);
        ynan  = (ey == 11'h7FF) && (r0_y[51:0] != 52'd0);
        xinf  = (ex == 11'h7FF) && (r0_x[51:0] == 52'd0);
        yinf  = (ey == 11'h7FF) && (r0_y[51:0] == 52'd0);
        xzero = r0_x[62:0] == 63'd0;
        yzero = r0_y[62:0] == 63'd0;
        cls.sgn  = r0_x[63] ^ r0_y[63];
        cls.nan  = xnan | ynan | (xinf & yzero) | (yinf & xzero);
        cls.inf  = xinf | yinf;
        cls.zero = xzero | yzero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            rA_v <= 1'b0;
            rB_v <= 1'b0;
            rC_v <= 1'b0;
        end else begin
            r0_v <= accept;
            rA_v <= r0_v;
            rB_v <= rA_v;
            rC_v <= rB_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r0_x    <= i_x_element;
            r0_y    <= i_y_element;
            r0_last <= i_last_element;
        end
        rA_pll  <= ma[31:0] * mb[31:0];
        rA_plh  <= ma[31:0] * mb[52:32];
        rA_phl  <= ma[52:32] * mb[31:0];
        rA_phh  <= ma[52:32] * mb[52:32];
        rA_be   <= 13'(ea) + 13'(eb) - 13'sd1022;
        rA_cls  <= cls;
        rA_last <= r0_last;

        rB_p    <= NORM_W'(rA_pll) + (NORM_W'(rA_plh) << 32) + (NORM_W'(rA_phl) << 32)
                 + (NORM_W'(rA_phh) << 64);
        rB_be   <= rA_be;
        rB_cls  <= rA_cls;
        rB_last <= rA_last;

        rC_sn   <= rB_p << lz;
        rC_be   <= rB_be - 13'(lz);
        rC_cls  <= rB_cls;
        rC_last <= rB_last;
    end

    assign lz = lzc106(rB_p);

    always_comb begin
        if (rC_cls.nan) begin
            res = CANON_NAN;
        end else if (rC_cls.inf) begin
            res = {rC_cls.sgn, 11'h7FF, 52'd0};
        end else if (rC_cls.zero) begin
            res = {rC_cls.sgn, 63'd0};
        end else begin
            res = round_pack(rC_cls.sgn, rC_sn, rC_be);
        end
    end

    assign o_push           = rC_v;
    assign o_push_data.bits = res;
    assign o_push_data.last = rC_last;

endmodule

/* hw/rtl/ddpa_fifo.sv */
// Short product queue between the multiplier front end and the accumulating back end.
module ddpa_fifo
    import ddpa_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  t_prod                       i_data,
    input  logic                        i_pop,
    output t_prod                       o_head,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_prod          r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wp;
    logic [AW-1:0]  n_rp;

    assign n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CW'(DEPTH)))
        else $error("product pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("product popped from an empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_count == $past(r_count) + CW'($past(i_push)) - CW'($past(i_pop))))
        else $error("queue count lost track of pushes and pops");

endmodule

/* hw/rtl/ddpa_back.sv */
// Back end: sequential binary64 accumulate of queued products and result register.
module ddpa_back
    import ddpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_prod       i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_dot_result
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [63:0]        r_acc;
    t_prod              r_b;
    logic [56:0]        r_s;
    logic [10:0]        r_ebig;
    logic               r_sgn;
    logic               r_zero;
    logic               r_nan;
    logic               r_inf;
    logic               r_isgn;
    logic [NORM_W-1:0]  r_sn;
    logic signed [12:0] r_be;
    logic               r_out_v;
    logic [63:0]        r_out;

    logic          can_pop;
    logic [63:0]   a, b, big, sml;
    logic          a_big;
    logic [10:0]   ebig, esml, diff;
    logic [52:0]   mbig, msml;
    logic [55:0]   am, bm, bsh;
    logic          stk, sub;
    logic [56:0]   s;
    logic          anan, bnan, ainf, binf;
    logic [NORM_W-1:0] padded;
    logic [6:0]    lz;
    logic [63:0]   res;

    assign can_pop = !i_empty && !(i_head.last && r_out_v);

    always_comb begin
        case (r_state)
            ST_IDLE:  n_state = can_pop ? ST_ALIGN : ST_IDLE;
            ST_ALIGN: n_state = ST_NORM;
            ST_NORM:  n_state = ST_ROUND;
            ST_ROUND: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_IDLE: o_pop = can_pop;
            default: o_pop = 1'b0;
        endcase
    end

    // Alignment and add of the running sum and the product.
    always_comb begin
        a     = r_acc;
        b     = r_b.bits;
        a_big = a[62:0] >= b[62:0];
        big   = a_big ? a : b;
        sml   = a_big ? b : a;
        ebig  = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
        esml  = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
        mbig  = {big[62:52] != 11'd0, big[51:0]};
        msml  = {sml[62:52] != 11'd0, sml[51:0]};
        diff  = ebig - esml;
        am    = {mbig, 3'b000};
        bm    = {msml, 3'b000};
        if (diff >= 11'd56) begin
            bsh = '0;
            stk = |msml;
        end else begin
            bsh = bm >> diff;
            stk = |(bm & ~({56{1'b1}} << diff));
        end
        bsh[0] = bsh[0] | stk;
        sub    = a[63] ^ b[63];
        s      = sub ? ({1'b0, am} - {1'b0, bsh}) : ({1'b0, am} + {1'b0, bsh});
        anan   = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        bnan   = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        ainf   = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
        binf   = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    end

    assign padded = {r_s, 49'd0};
    assign lz     = lzc106(padded);

    always_comb begin
        if (r_nan) begin
            res = CANON_NAN;
        end else if (r_inf) begin
            res = {r_isgn, 11'h7FF, 52'd0};
        end else if (r_zero) begin
            res = {r_sgn, 63'd0};
        end else begin
            res = round_pack(r_sgn, r_sn, r_be);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_acc   <= 64'd0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if (r_state == ST_ROUND) begin
                r_acc <= r_b.last ? 64'd0 : res;
                if (r_b.last) begin
                    r_out_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b <= i_head;
        end
        if (r_state == ST_ALIGN) begin
            r_s    <= s;
            r_ebig <= ebig;
            r_zero <= s == 57'd0;
            r_sgn  <= (s == 57'd0) ? (a[63] & b[63]) : big[63];
            r_nan  <= anan | bnan | (ainf & binf & sub);
            r_inf  <= ainf | binf;
            r_isgn <= ainf ? a[63] : b[63];
        end
        if (r_state == ST_NORM) begin
            r_sn <= padded << lz;
            r_be <= 13'(r_ebig) + 13'sd1 - 13'(lz);
        end
        if (r_state == ST_ROUND && r_b.last) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_out_v;
    assign o_dot_result = r_out;

endmodule

/* hw/rtl/double_dot_product_accumulator_core.sv */
// Top level of the binary64 dot product accumulator.
// Each input beat carries one pair of IEEE-754 binary64 elements; the pair is multiplied
// with round-to-nearest-even, and the rounded product is added, again rounded on its own,
// to a running sum that starts at +0.0. The beat flagged by last_element closes the
// vector: the final sum leaves on the output channel and the sum returns to +0.0. Any NaN
// result is reported as the quiet NaN 0x7FF8000000000000, subnormals are fully supported,
// and a vector always holds at least its last beat. Throughput is set by the
// accumulation loop in the back end, where each add (align, normalize, round, and the
// fetch of the next product) must finish before the next one can read the running sum.
// The front end is a four-stage multiplier pipeline that takes a beat in any cycle
// while its queue has room, so short bursts are absorbed by the product queue of
// QUEUE_DEPTH entries. A beat's result, when it has one, passes through the multiplier,
// the queue and the back end to its own output register. The block keeps accepting
// beats while a result waits, but a next last product stays queued until it is taken.
module double_dot_product_accumulator_core
    import ddpa_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_x_element,
    input  logic [63:0] i_y_element,
    input  logic        i_last_element,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_dot_result
);

    logic                              push;
    t_prod                             push_data;
    logic                              pop;
    t_prod                             head;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]  count;

    // Multiplier pipeline; it holds back new beats when the queue could overflow.
    ddpa_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_x_element    (i_x_element),
        .i_y_element    (i_y_element),
        .i_last_element (i_last_element),
        .i_fifo_count   (count),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    // Rounded products wait here for the accumulator.
    ddpa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (count)
    );

    // Sequential accumulator and output register.
    ddpa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (count == '0),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_dot_result (o_dot_result)
    );

endmodule
